// ===== hw/rtl/salc_pkg.sv =====
`default_nettype none

package salc_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES_LOG2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT_LOG2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH_ON      = 3'd3;

    localparam int CFG_BLOCK_W = 4;
    localparam int CFG_SETS_W  = 3;
    localparam int CFG_WAYS_W  = 3;

    localparam logic [CFG_BLOCK_W-1:0] RST_BLOCK_BYTES_LOG2 = 4'd4;
    localparam logic [CFG_SETS_W-1:0]  RST_SET_COUNT_LOG2   = 3'd6;
    localparam logic [CFG_WAYS_W-1:0]  RST_WAYS_IN_USE      = 3'd1;
    localparam logic                   RST_PREFETCH_ON      = 1'b0;

    // Recency rank: 0 is most recently used, saturates at RANK_MAX.
    localparam int RANK_W = 2;
    localparam logic [RANK_W-1:0] RANK_MRU = 2'd0;
    localparam logic [RANK_W-1:0] RANK_MAX = 2'd3;

    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEM  = 4'b0010,
        S_PRE  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    function automatic logic [RANK_W-1:0] rank_up(input logic [RANK_W-1:0] r);
        return (r == RANK_MAX) ? r : r + RANK_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/set_assoc_lru_cache_tag_model.sv =====
`default_nettype none

// Set-associative tag store with true LRU replacement and optional next-block
// prefetch. Each item is a byte address; each item returns one result with
// the demand hit flag, whether prefetch inserted the next block, and the
// saturating hit and miss totals after that item. The tags and ranks of a set
// sit in one synchronous memory row with a registered read, and every lookup
// is a read followed by an update and write of the row (the prefetch read
// overlaps the demand write, with the written row forwarded when both hit the
// same set). A new item is taken while a finished result still waits at the
// output. Line valid bits are flip-flops, cleared at once by reset and by any
// write to the block size, set count or way count registers, so no clearing
// pass is needed. The user must write configuration only while the block is
// idle; the block itself does not enforce it.
module set_assoc_lru_cache_tag_model
    import salc_pkg::*;
#(
    parameter int MAX_SETS  = 64,
    parameter int MAX_WAYS  = 4,
    parameter int ADDR_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [31:0]           i_byte_address,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_hit,
    output logic                       o_prefetch_filled,
    output logic [CNT_W-1:0]           o_hit_total,
    output logic [CNT_W-1:0]           o_miss_total
);

    localparam int AW        = ADDR_BITS;
    localparam int SLM       = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_DEPTH = 1 << SLM;
    localparam int SIW       = (SLM > 0) ? SLM : 1;
    localparam int WIW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WU_W      = ($clog2(MAX_WAYS + 1) > CFG_WAYS_W) ?
                               $clog2(MAX_WAYS + 1) : CFG_WAYS_W;

    typedef logic [MAX_WAYS-1:0][AW-1:0]     t_row_tags;
    typedef logic [MAX_WAYS-1:0][RANK_W-1:0] t_row_ranks;

    function automatic logic [SIW-1:0] set_of(input logic [AW-1:0] blk,
                                              input logic [3:0] s);
        logic [SIW-1:0] m;
        for (int b = 0; b < SIW; b++) begin
            m[b] = (b < int'(s));
        end
        return blk[SIW-1:0] & m;
    endfunction

    // Configuration.
    logic [CFG_BLOCK_W-1:0] r_bbl;
    logic [CFG_SETS_W-1:0]  r_scl;
    logic [CFG_WAYS_W-1:0]  r_wiu;
    logic                   r_pf;
    logic                   flush;

    // Control and datapath registers.
    t_state              r_state, n_state;
    logic [SIW-1:0]      r_set;
    logic [AW-1:0]       r_tag;
    logic [AW-1:0]       r_next;
    logic                r_fwd;
    t_row_tags           r_fwd_tags;
    t_row_ranks          r_fwd_ranks;
    logic                r_dem_hit;
    logic [CNT_W-1:0]    r_hit_cnt, n_hit_cnt;
    logic [CNT_W-1:0]    r_miss_cnt, n_miss_cnt;
    logic [MAX_WAYS-1:0] r_valid [SET_DEPTH];

    // Memory.
    t_row_tags  mem_tags  [SET_DEPTH];
    t_row_ranks mem_ranks [SET_DEPTH];
    t_row_tags  r_rd_tags;
    t_row_ranks r_rd_ranks;
    logic [SIW-1:0] rd_addr;
    logic           mem_we;

    // Output and pending result.
    logic             r_out_valid;
    logic             r_out_hit, r_out_filled;
    logic [CNT_W-1:0] r_out_hits, r_out_misses;
    logic             r_pend_hit, r_pend_filled;
    logic [CNT_W-1:0] r_pend_hits, r_pend_misses;

    logic             in_acc, slot_free, fin;
    logic             res_hit, res_filled;

    // Address split.
    logic [3:0]      s_used;
    logic [WU_W-1:0] ways_used;
    logic [AW-1:0]   addr_in, blk_in, blk_next;
    logic [SIW-1:0]  dset, pset;
    logic [AW-1:0]   dtag, ptag;

    // Row update.
    t_row_tags           cur_tags, n_row_tags;
    t_row_ranks          cur_ranks, n_row_ranks;
    logic [MAX_WAYS-1:0] cur_valid, n_row_valid;
    logic [MAX_WAYS-1:0] inuse, match, free;
    logic                hit_any, free_any, has3, has2, has1;
    logic [WIW-1:0]      hway, fway, vway, slot;
    logic [RANK_W-1:0]   maxr, hrank;

    always_comb begin
        s_used = ({1'b0, r_scl} > 4'(SLM)) ? 4'(SLM) : {1'b0, r_scl};
        if (WU_W'(r_wiu) == '0) begin
            ways_used = WU_W'(1);
        end else if (WU_W'(r_wiu) > WU_W'(MAX_WAYS)) begin
            ways_used = WU_W'(MAX_WAYS);
        end else begin
            ways_used = WU_W'(r_wiu);
        end
    end

    assign addr_in  = AW'(i_byte_address);
    assign blk_in   = addr_in >> r_bbl;
    assign blk_next = r_next >> r_bbl;
    assign dset     = set_of(blk_in, s_used);
    assign dtag     = blk_in >> s_used;
    assign pset     = set_of(blk_next, s_used);
    assign ptag     = blk_next >> s_used;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || i_out_ready;
    assign fin        = ((r_state == S_DEM) && !r_pf) || (r_state == S_PRE);
    assign flush      = i_cfg_we && ((i_cfg_idx == CFG_BLOCK_BYTES_LOG2) ||
                                     (i_cfg_idx == CFG_SET_COUNT_LOG2) ||
                                     (i_cfg_idx == CFG_WAYS_IN_USE));

    // Lookup and LRU update of the set row currently in flight.
    always_comb begin
        if (r_fwd && (r_state == S_PRE)) begin
            cur_tags  = r_fwd_tags;
            cur_ranks = r_fwd_ranks;
        end else begin
            cur_tags  = r_rd_tags;
            cur_ranks = r_rd_ranks;
        end
        cur_valid = r_valid[r_set];

        for (int i = 0; i < MAX_WAYS; i++) begin
            inuse[i] = (WU_W'(i) < ways_used);
            match[i] = inuse[i] && cur_valid[i] && (cur_tags[i] == r_tag);
            free[i]  = inuse[i] && !cur_valid[i];
        end
        hit_any  = |match;
        free_any = |free;

        has3 = 1'b0;
        has2 = 1'b0;
        has1 = 1'b0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            has3 = has3 | (inuse[i] && (cur_ranks[i] == 2'd3));
            has2 = has2 | (inuse[i] && (cur_ranks[i] == 2'd2));
            has1 = has1 | (inuse[i] && (cur_ranks[i] == 2'd1));
        end
        maxr = has3 ? 2'd3 : has2 ? 2'd2 : has1 ? 2'd1 : 2'd0;

        hway = '0;
        fway = '0;
        vway = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hway = WIW'(i);
            end
            if (free[i]) begin
                fway = WIW'(i);
            end
            if (inuse[i] && (cur_ranks[i] == maxr)) begin
                vway = WIW'(i);
            end
        end
        slot  = free_any ? fway : vway;
        hrank = cur_ranks[hway];

        n_row_tags  = cur_tags;
        n_row_ranks = cur_ranks;
        n_row_valid = cur_valid;
        if (hit_any) begin
            // A prefetch that finds its block leaves the recency untouched.
            if (r_state == S_DEM) begin
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if (WIW'(i) == hway) begin
                        n_row_ranks[i] = RANK_MRU;
                    end else if (cur_valid[i] && (cur_ranks[i] < hrank)) begin
                        n_row_ranks[i] = rank_up(cur_ranks[i]);
                    end
                end
            end
        end else begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                if (WIW'(i) == slot) begin
                    n_row_tags[i]  = r_tag;
                    n_row_ranks[i] = RANK_MRU;
                    n_row_valid[i] = 1'b1;
                end else if (cur_valid[i]) begin
                    n_row_ranks[i] = rank_up(cur_ranks[i]);
                end
            end
        end
    end

    assign mem_we = (r_state == S_DEM) || ((r_state == S_PRE) && !hit_any);

    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = dset;
            S_DEM:   rd_addr = pset;
            default: rd_addr = r_set;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_tags[r_set]  <= n_row_tags;
            mem_ranks[r_set] <= n_row_ranks;
        end
        r_rd_tags  <= mem_tags[rd_addr];
        r_rd_ranks <= mem_ranks[rd_addr];
    end

    // Counters and result.
    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (r_state == S_DEM) begin
            if (hit_any) begin
                if (r_hit_cnt != CNT_MAX) begin
                    n_hit_cnt = r_hit_cnt + CNT_W'(1);
                end
            end else if (r_miss_cnt != CNT_MAX) begin
                n_miss_cnt = r_miss_cnt + CNT_W'(1);
            end
        end
        res_hit    = (r_state == S_DEM) ? hit_any : r_dem_hit;
        res_filled = (r_state == S_PRE) && !hit_any;
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = in_acc ? S_DEM : S_IDLE;
            S_DEM:   n_state = r_pf ? S_PRE : (slot_free ? S_IDLE : S_HOLD);
            S_PRE:   n_state = slot_free ? S_IDLE : S_HOLD;
            S_HOLD:  n_state = slot_free ? S_IDLE : S_HOLD;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bbl       <= RST_BLOCK_BYTES_LOG2;
            r_scl       <= RST_SET_COUNT_LOG2;
            r_wiu       <= RST_WAYS_IN_USE;
            r_pf        <= RST_PREFETCH_ON;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
            for (int s = 0; s < SET_DEPTH; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BLOCK_BYTES_LOG2: r_bbl <= i_cfg_data[CFG_BLOCK_W-1:0];
                    CFG_SET_COUNT_LOG2:   r_scl <= i_cfg_data[CFG_SETS_W-1:0];
                    CFG_WAYS_IN_USE:      r_wiu <= i_cfg_data[CFG_WAYS_W-1:0];
                    CFG_PREFETCH_ON:      r_pf  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (flush) begin
                for (int s = 0; s < SET_DEPTH; s++) begin
                    r_valid[s] <= '0;
                end
            end else if (mem_we) begin
                r_valid[r_set] <= n_row_valid;
            end
            // The prefetch read shares its cycle with the demand write, so a
            // prefetch into the same set takes the row just written.
            if (r_state == S_DEM) begin
                r_fwd <= (pset == r_set);
            end
            if ((fin || (r_state == S_HOLD)) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_set  <= dset;
            r_tag  <= dtag;
            r_next <= addr_in + (AW'(1) << r_bbl);
        end else if (r_state == S_DEM) begin
            r_set       <= pset;
            r_tag       <= ptag;
            r_fwd_tags  <= n_row_tags;
            r_fwd_ranks <= n_row_ranks;
            r_dem_hit   <= hit_any;
        end
        if (fin && slot_free) begin
            r_out_hit    <= res_hit;
            r_out_filled <= res_filled;
            r_out_hits   <= n_hit_cnt;
            r_out_misses <= n_miss_cnt;
        end else if ((r_state == S_HOLD) && slot_free) begin
            r_out_hit    <= r_pend_hit;
            r_out_filled <= r_pend_filled;
            r_out_hits   <= r_pend_hits;
            r_out_misses <= r_pend_misses;
        end
        if (fin && !slot_free) begin
            r_pend_hit    <= res_hit;
            r_pend_filled <= res_filled;
            r_pend_hits   <= n_hit_cnt;
            r_pend_misses <= n_miss_cnt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_prefetch_filled = r_out_filled;
    assign o_hit_total       = r_out_hits;
    assign o_miss_total      = r_out_misses;

endmodule

`default_nettype wire
